// File: design/ipfc_pkg.sv
// Shared constants, codes and types of the indexed pixel format converter.
`default_nettype none

package ipfc_pkg;

  // Palette geometry.
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_IDX_W     = $clog2(PALETTE_DEPTH);
  localparam int COUNT_W       = 9;
  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(PALETTE_DEPTH);

  // Register port geometry: eight registers at 8-byte strides.
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // Channel scaling: (c * max + 127) / 255, the division done as a
  // multiply by ceil(2^33 / 255) followed by a right shift of 33.
  localparam int SUM_W   = 24;
  localparam int RECIP_W = 26;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 33;
  localparam logic [RECIP_W-1:0] RECIP_255  = 26'd33686019;
  localparam logic [SUM_W-1:0]   ROUND_BIAS = 24'd127;

  // Wire layout.
  localparam logic [2:0] MAX_BYTES = 3'd4;

  // Item function codes.
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  // Register indexes.
  typedef enum logic [2:0] {
    REG_PIXEL_BYTES    = 3'd0,
    REG_MSB_FIRST      = 3'd1,
    REG_CHANNEL_MAXIMA = 3'd2,
    REG_RED_SHIFT      = 3'd3,
    REG_GREEN_SHIFT    = 3'd4,
    REG_BLUE_SHIFT     = 3'd5,
    REG_COLOR_COUNT    = 3'd6,
    REG_TWO_COLOR_PAIR = 3'd7
  } reg_idx_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [2:0]         pixel_bytes;
    logic               msb_first;
    logic [47:0]        channel_maxima;
    logic [4:0]         red_shift;
    logic [4:0]         green_shift;
    logic [4:0]         blue_shift;
    logic [COUNT_W-1:0] color_count;
    logic [47:0]        two_color_pair;
  } cfg_t;

  // Color source control travelling with a pixel out of the lookup stage.
  typedef struct packed {
    logic two_color;
    logic fg_sel;
  } lookup_ctl_t;

  // Three scaled channels: index 2 red, 1 green, 0 blue.
  typedef logic [2:0][15:0] chan_t;

endpackage

`default_nettype wire

// File: design/ipfc_if.sv
// Valid/ready stream interfaces for pixel items and wire pixel results.
`default_nettype none

interface ipfc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  entry_index;
  logic [23:0] entry_rgb;
  logic [7:0]  pixel_value;

  modport source (output valid, func, entry_index, entry_rgb, pixel_value, input ready);
  modport sink (input valid, func, entry_index, entry_rgb, pixel_value, output ready);
endinterface

interface ipfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] wire_word;
  logic [2:0]  byte_count;

  modport source (output valid, wire_word, byte_count, input ready);
  modport sink (input valid, wire_word, byte_count, output ready);
endinterface

`default_nettype wire

// File: design/ipfc_regs.sv
// APB-style configuration register file.
`default_nettype none

module ipfc_regs
  import ipfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; all fields return to their documented reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_bytes    <= 3'd4;
      cfg.msb_first      <= 1'b0;
      cfg.channel_maxima <= 48'h00FF_00FF_00FF;
      cfg.red_shift      <= 5'd16;
      cfg.green_shift    <= 5'd8;
      cfg.blue_shift     <= 5'd0;
      cfg.color_count    <= '0;
      cfg.two_color_pair <= 48'hFFFF_FF00_0000;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PIXEL_BYTES:    cfg.pixel_bytes    <= pwdata[2:0];
        REG_MSB_FIRST:      cfg.msb_first      <= pwdata[0];
        REG_CHANNEL_MAXIMA: cfg.channel_maxima <= pwdata[47:0];
        REG_RED_SHIFT:      cfg.red_shift      <= pwdata[4:0];
        REG_GREEN_SHIFT:    cfg.green_shift    <= pwdata[4:0];
        REG_BLUE_SHIFT:     cfg.blue_shift     <= pwdata[4:0];
        REG_COLOR_COUNT:    cfg.color_count    <= pwdata[COUNT_W-1:0];
        REG_TWO_COLOR_PAIR: cfg.two_color_pair <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      REG_PIXEL_BYTES:    prdata = DATA_W'(cfg.pixel_bytes);
      REG_MSB_FIRST:      prdata = DATA_W'(cfg.msb_first);
      REG_CHANNEL_MAXIMA: prdata = DATA_W'(cfg.channel_maxima);
      REG_RED_SHIFT:      prdata = DATA_W'(cfg.red_shift);
      REG_GREEN_SHIFT:    prdata = DATA_W'(cfg.green_shift);
      REG_BLUE_SHIFT:     prdata = DATA_W'(cfg.blue_shift);
      REG_COLOR_COUNT:    prdata = DATA_W'(cfg.color_count);
      REG_TWO_COLOR_PAIR: prdata = DATA_W'(cfg.two_color_pair);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/ipfc_lookup.sv
// Stage 1: palette memory write, index clamp and registered palette read.
`default_nettype none

module ipfc_lookup
  import ipfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic        in_valid,
  input  wire logic        func,
  input  wire logic [7:0]  entry_index,
  input  wire logic [23:0] entry_rgb,
  input  wire logic [7:0]  pixel_value,
  input  wire cfg_t        cfg,
  output logic             s1_valid,
  output lookup_ctl_t      s1_ctl,
  output logic [23:0]      s1_rgb
);

  logic [23:0]          palette [PALETTE_DEPTH];
  logic                 accept;
  logic [COUNT_W-1:0]   count_eff;
  logic [COUNT_W-1:0]   pix_ext;
  logic [COUNT_W-1:0]   idx_clamped;
  logic [PAL_IDX_W-1:0] rd_idx;
  logic                 wr_hit;

  assign accept = in_valid && advance;

  // Entries in use never exceed the store; the index is clamped to the last one.
  assign count_eff   = (cfg.color_count > DEPTH_COUNT) ? DEPTH_COUNT : cfg.color_count;
  assign pix_ext     = COUNT_W'(pixel_value);
  assign idx_clamped = (pix_ext >= count_eff) ? (count_eff - COUNT_W'(1)) : pix_ext;
  assign rd_idx      = idx_clamped[PAL_IDX_W-1:0];
  assign wr_hit      = (COUNT_W'(entry_index) < DEPTH_COUNT);

  // Palette writes land on accepted write beats whose slot exists.
  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_WRITE) && wr_hit) begin
      palette[entry_index[PAL_IDX_W-1:0]] <= entry_rgb;
    end
  end

  // Registered read; it holds while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_rgb        <= palette[rd_idx];
      s1_ctl.two_color <= (count_eff == '0);
      s1_ctl.fg_sel    <= (pixel_value != 8'd0);
    end
  end

  // Only convert beats make a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid && (func == FUNC_CONVERT);
    end
  end

endmodule

`default_nettype wire

// File: design/ipfc_scale.sv
// Stages 2 and 3: color select, channel multiply-round and reciprocal divide by 255.
`default_nettype none

module ipfc_scale
  import ipfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic        s1_valid,
  input  wire lookup_ctl_t s1_ctl,
  input  wire logic [23:0] s1_rgb,
  input  wire cfg_t        cfg,
  output logic             s3_valid,
  output chan_t            s3_chan
);

  logic [23:0]            rgb;
  logic [2:0][SUM_W-1:0]  sum;
  logic [2:0][SUM_W-1:0]  s2_sum;
  logic [2:0][PROD_W-1:0] recip_prod;
  logic                   s2_valid;

  // Color source: two-color pair or palette entry.
  always_comb begin
    if (s1_ctl.two_color) begin
      rgb = s1_ctl.fg_sel ? cfg.two_color_pair[47:24] : cfg.two_color_pair[23:0];
    end else begin
      rgb = s1_rgb;
    end
  end

  // Per-channel c * max + 127; the result stays below 2^24.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SUM_W'(rgb[8*c +: 8]) * SUM_W'(cfg.channel_maxima[16*c +: 16]) + ROUND_BIAS;
    end
  end

  // Divide by 255 as a reciprocal multiply, exact for sums below 2^24.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      recip_prod[c] = PROD_W'(s2_sum[c]) * PROD_W'(RECIP_255);
    end
  end

  // Stage 2 and stage 3 data registers.
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_sum <= sum;
      for (int c = 0; c < 3; c++) begin
        s3_chan[c] <= recip_prod[c][RECIP_SHIFT +: 16];
      end
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

endmodule

`default_nettype wire

// File: design/ipfc_pack.sv
// Stage 4: field placement, wire byte layout and the output register.
`default_nettype none

module ipfc_pack
  import ipfc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   advance,
  input  wire logic   s3_valid,
  input  wire chan_t  s3_chan,
  input  wire cfg_t   cfg,
  output logic        out_valid,
  output logic [31:0] wire_word,
  output logic [2:0]  byte_count
);

  logic [31:0] val;
  logic [2:0]  nbytes;
  logic [1:0]  pos;
  logic [31:0] word;

  // Shift each scaled channel into place; bits past 31 fall off.
  assign val = ((32'(s3_chan[2])) << cfg.red_shift) |
               ((32'(s3_chan[1])) << cfg.green_shift) |
               ((32'(s3_chan[0])) << cfg.blue_shift);

  // Zero or anything above four bytes means four.
  assign nbytes = ((cfg.pixel_bytes == 3'd0) || (cfg.pixel_bytes > MAX_BYTES)) ?
                  MAX_BYTES : cfg.pixel_bytes;

  // Lay out the low nbytes bytes, reversed when most significant goes first.
  always_comb begin
    word = '0;
    pos  = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < nbytes) begin
        pos  = cfg.msb_first ? 2'(nbytes - 3'(i) - 3'd1) : 2'(i);
        word = word | ((32'(val[8*i +: 8])) << {pos, 3'b000});
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      wire_word  <= word;
      byte_count <= nbytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s3_valid;
    end
  end

endmodule

`default_nettype wire

// File: design/indexed_pixel_format_converter_core.sv
// Top level of the indexed pixel format converter.
// Throughput: one beat per cycle while the output is not stalled.
// A write beat occupies one slot and gives no result.
// The four stages are lookup, multiply-round, reciprocal divide and pack/output.
// All stages hold together while a result waits at the output.
// Synchronous reset: valid bits clear, config to defaults; data, palette undefined.
`default_nettype none

module indexed_pixel_format_converter_core
  import ipfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  ipfc_in_if.sink                pix_in,
  ipfc_out_if.source             pix_out,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t        cfg;
  logic        advance;
  logic        s1_valid;
  lookup_ctl_t s1_ctl;
  logic [23:0] s1_rgb;
  logic        s3_valid;
  chan_t       s3_chan;

  // The pipeline moves unless a result is waiting to be taken.
  assign advance      = !(pix_out.valid && !pix_out.ready);
  assign pix_in.ready = advance;

  // Configuration registers.
  ipfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1: palette.
  ipfc_lookup u_lookup (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_valid    (pix_in.valid),
    .func        (pix_in.func),
    .entry_index (pix_in.entry_index),
    .entry_rgb   (pix_in.entry_rgb),
    .pixel_value (pix_in.pixel_value),
    .cfg         (cfg),
    .s1_valid    (s1_valid),
    .s1_ctl      (s1_ctl),
    .s1_rgb      (s1_rgb)
  );

  // Stages 2 and 3: channel scaling.
  ipfc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_rgb   (s1_rgb),
    .cfg      (cfg),
    .s3_valid (s3_valid),
    .s3_chan  (s3_chan)
  );

  // Stage 4: packing and output register.
  ipfc_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .s3_valid   (s3_valid),
    .s3_chan    (s3_chan),
    .cfg        (cfg),
    .out_valid  (pix_out.valid),
    .wire_word  (pix_out.wire_word),
    .byte_count (pix_out.byte_count)
  );

  // An accepted beat enters stage 1 as valid exactly when it is a convert beat.
  a_stage1_entry: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> (s1_valid == $past(pix_in.func == FUNC_CONVERT)))
    else $error("stage 1 valid does not match accepted beat function");

  // An item leaving stage 3 appears at the output.
  a_stage3_exit: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && advance) |=> pix_out.valid)
    else $error("stage 3 item lost before the output register");

  // A result always carries one to four bytes.
  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> ((pix_out.byte_count != 3'd0) && (pix_out.byte_count <= MAX_BYTES)))
    else $error("byte count out of range");

  // A stage 3 item is held while the output is stalled.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!advance && s3_valid) |=> s3_valid)
    else $error("stage 3 item dropped during a stall");

endmodule

`default_nettype wire
